>>> hw/rtl/prqs_pkg.sv
`timescale 1ns / 1ps
`default_nettype none

package prqs_pkg;

  // Widths of the command and result fields.
  localparam int CMD_W      = 2;
  localparam int TASK_ID_W  = 4;
  localparam int PRIO_W     = 5;
  localparam int STATUS_W   = 2;

  // Default sizes of the task table and the level table.
  localparam int MAX_TASKS_DEF       = 16;
  localparam int PRIORITY_LEVELS_DEF = 32;

  // The level search works on groups of sixteen flags, sixteen groups at most.
  localparam int GROUP_W   = 16;
  localparam int MAP_PAD_W = GROUP_W * GROUP_W;

  // Command codes.
  localparam logic [CMD_W-1:0] CMD_ADD   = 2'd0;
  localparam logic [CMD_W-1:0] CMD_START = 2'd1;
  localparam logic [CMD_W-1:0] CMD_SCHED = 2'd2;

  // Result status codes.
  localparam logic [STATUS_W-1:0] STATUS_OK     = 2'd0;
  localparam logic [STATUS_W-1:0] STATUS_EMPTY  = 2'd1;
  localparam logic [STATUS_W-1:0] STATUS_MISUSE = 2'd2;

  // Steps that the controller asks of the datapath.
  typedef struct packed {
    logic ld_req;
    logic srch0;
    logic srch1;
    logic take_next;
    logic unl1;
    logic unl2;
    logic push0;
    logic push1;
    logic fin;
    logic set_empty;
    logic ld_out;
  } prqs_ctl_t;

  // Conditions that the datapath reports back.
  typedef struct packed {
    logic [CMD_W-1:0] cmd_in;
    logic             req_ok;
    logic [CMD_W-1:0] cmd_q;
    logic             cur_run;
    logic             found;
    logic             do_switch;
    logic             out_free;
  } prqs_sts_t;

  // Index of the lowest set bit, zero when no bit is set.
  function automatic logic [3:0] first_set16(input logic [GROUP_W-1:0] v);
    logic [3:0] idx;
    idx = 4'd0;
    for (int i = GROUP_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        idx = 4'(i);
      end
    end
    return idx;
  endfunction

endpackage

`default_nettype wire

>>> hw/rtl/prqs_if.sv
`timescale 1ns / 1ps
`default_nettype none

interface prqs_req_if import prqs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [CMD_W-1:0]     command;
  logic [TASK_ID_W-1:0] task_id;
  logic [PRIO_W-1:0]    priority_req;
  logic                 current_running;
  logic                 in_interrupt;

  modport source (
    output valid, command, task_id, priority_req, current_running, in_interrupt,
    input  ready
  );
  modport sink (
    input  valid, command, task_id, priority_req, current_running, in_interrupt,
    output ready
  );
endinterface

interface prqs_rsp_if import prqs_pkg::*; ();
  logic                 valid;
  logic                 ready;
  logic [STATUS_W-1:0]  status;
  logic                 switched;
  logic [TASK_ID_W-1:0] from_task;
  logic [TASK_ID_W-1:0] to_task;
  logic                 lazy_switch;

  modport source (
    output valid, status, switched, from_task, to_task, lazy_switch,
    input  ready
  );
  modport sink (
    input  valid, status, switched, from_task, to_task, lazy_switch,
    output ready
  );
endinterface

`default_nettype wire

>>> hw/rtl/priority_ready_queue_scheduler_core.sv
// Ready-queue task scheduler with one FIFO per priority level (0 is best).
// Command words arrive on req (valid/ready): add a task to the tail of its
// level, start a queued task, or schedule. Each command word yields exactly
// one result word on rsp (valid/ready) with status, switch flag, the current
// task before and after, and the deferred-switch flag for schedules from
// interrupts.
// Commands are processed one at a time. A rejected command goes straight
// to its result; a schedule that switches drops the current task, or puts
// it back at the tail of its queue while it is still running. req is
// ready again the cycle after the result is loaded. The steps follow the
// chain of dependent reads of the link, level, head and tail memories,
// each of which has a registered read port.
// A finished result sits in an output register, so the next command word is
// accepted while it waits; if the receiver keeps stalling, the following
// result waits in the scheduler and req stays low until rsp frees up.
// Synchronous reset empties all queues and clears the current task; the
// link and head/tail memories need no clearing pass, because an entry is
// always written before its value is used.
`timescale 1ns / 1ps
`default_nettype none

module priority_ready_queue_scheduler_core import prqs_pkg::*; #(
  parameter int MAX_TASKS       = MAX_TASKS_DEF,
  parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
) (
  input  wire logic clk,
  input  wire logic rst,
  prqs_req_if.sink  req,
  prqs_rsp_if.source rsp
);

  prqs_ctl_t ctl;
  prqs_sts_t sts;
  logic      idle;
  logic      accept;

  // A command word is taken only while the sequencer is idle.
  assign req.ready = idle;
  assign accept    = req.valid && idle;

  prqs_ctrl u_ctrl (
    .clk    (clk),
    .rst    (rst),
    .accept (accept),
    .sts    (sts),
    .idle   (idle),
    .ctl    (ctl)
  );

  // The datapath owns the queue memories, flags, current task and the
  // output register that holds a finished result word.
  prqs_dp #(
    .MAX_TASKS       (MAX_TASKS),
    .PRIORITY_LEVELS (PRIORITY_LEVELS)
  ) u_dp (
    .clk             (clk),
    .rst             (rst),
    .ctl             (ctl),
    .sts             (sts),
    .command         (req.command),
    .task_id         (req.task_id),
    .priority_req    (req.priority_req),
    .current_running (req.current_running),
    .in_interrupt    (req.in_interrupt),
    .out_valid       (rsp.valid),
    .out_ready       (rsp.ready),
    .status          (rsp.status),
    .switched        (rsp.switched),
    .from_task       (rsp.from_task),
    .to_task         (rsp.to_task),
    .lazy_switch     (rsp.lazy_switch)
  );

endmodule

`default_nettype wire

>>> hw/rtl/prqs_ram.sv
`timescale 1ns / 1ps
`default_nettype none

module prqs_ram #(
  parameter int WIDTH = 4,
  parameter int DEPTH = 16
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

`default_nettype wire

>>> hw/rtl/prqs_ctrl.sv
`timescale 1ns / 1ps
`default_nettype none

module prqs_ctrl import prqs_pkg::*; (
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      accept,
  input  wire prqs_sts_t sts,
  output logic           idle,
  output prqs_ctl_t      ctl
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_SRCH0 = 4'd1;
  localparam logic [3:0] S_SRCH1 = 4'd2;
  localparam logic [3:0] S_SRCH2 = 4'd3;
  localparam logic [3:0] S_UNL0  = 4'd4;
  localparam logic [3:0] S_UNL1  = 4'd5;
  localparam logic [3:0] S_UNL2  = 4'd6;
  localparam logic [3:0] S_PUSH0 = 4'd7;
  localparam logic [3:0] S_PUSH1 = 4'd8;
  localparam logic [3:0] S_FIN   = 4'd9;
  localparam logic [3:0] S_DONE  = 4'd10;

  logic [3:0] state;
  logic [3:0] state_next;

  assign idle = (state == S_IDLE);

  always_comb begin
    state_next = state;
    ctl        = '0;
    case (state)
      S_IDLE: begin
        if (accept) begin
          ctl.ld_req = 1'b1;
          if (!sts.req_ok) begin
            state_next = S_DONE;
          end else begin
            case (sts.cmd_in)
              CMD_ADD:   state_next = S_PUSH0;
              CMD_START: state_next = S_UNL0;
              default:   state_next = S_SRCH0;
            endcase
          end
        end
      end
      S_SRCH0: begin
        ctl.srch0  = 1'b1;
        state_next = S_SRCH1;
      end
      S_SRCH1: begin
        ctl.srch1  = 1'b1;
        state_next = S_SRCH2;
      end
      S_SRCH2: begin
        if (!sts.found) begin
          ctl.set_empty = 1'b1;
          state_next    = S_DONE;
        end else if (sts.do_switch) begin
          ctl.take_next = 1'b1;
          state_next    = S_UNL0;
        end else begin
          state_next = S_DONE;
        end
      end
      S_UNL0: begin
        state_next = S_UNL1;
      end
      S_UNL1: begin
        ctl.unl1   = 1'b1;
        state_next = S_UNL2;
      end
      S_UNL2: begin
        ctl.unl2 = 1'b1;
        if (sts.cmd_q == CMD_SCHED && sts.cur_run) begin
          state_next = S_PUSH0;
        end else begin
          state_next = S_FIN;
        end
      end
      S_PUSH0: begin
        ctl.push0  = 1'b1;
        state_next = S_PUSH1;
      end
      S_PUSH1: begin
        ctl.push1  = 1'b1;
        state_next = (sts.cmd_q == CMD_ADD) ? S_DONE : S_FIN;
      end
      S_FIN: begin
        ctl.fin    = 1'b1;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (sts.out_free) begin
          ctl.ld_out = 1'b1;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

`default_nettype wire

>>> hw/rtl/prqs_dp.sv
`timescale 1ns / 1ps
`default_nettype none

module prqs_dp import prqs_pkg::*; #(
  parameter int MAX_TASKS       = MAX_TASKS_DEF,
  parameter int PRIORITY_LEVELS = PRIORITY_LEVELS_DEF
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire prqs_ctl_t            ctl,
  output prqs_sts_t                 sts,
  input  wire logic [CMD_W-1:0]     command,
  input  wire logic [TASK_ID_W-1:0] task_id,
  input  wire logic [PRIO_W-1:0]    priority_req,
  input  wire logic                 current_running,
  input  wire logic                 in_interrupt,
  output logic                      out_valid,
  input  wire logic                 out_ready,
  output logic [STATUS_W-1:0]       status,
  output logic                      switched,
  output logic [TASK_ID_W-1:0]      from_task,
  output logic [TASK_ID_W-1:0]      to_task,
  output logic                      lazy_switch
);

  localparam int TW = $clog2(MAX_TASKS);
  localparam int PW = $clog2(PRIORITY_LEVELS);

  // Control state.
  logic [MAX_TASKS-1:0]       queued_flags;
  logic [PRIORITY_LEVELS-1:0] nonempty_map;
  logic [TW-1:0]              running_task;
  logic                       running_valid;

  // Latched command.
  logic [CMD_W-1:0] cmd_q;
  logic [TW-1:0]    sel_task;
  logic [PW-1:0]    pr_q;
  logic             cur_run_q;
  logic             intr_q;

  // Working registers.
  logic [3:0]           gsel_q;
  logic                 found_q;
  logic [PW-1:0]        p_sel;
  logic [PW-1:0]        cur_p;
  logic [PW-1:0]        ul_p;
  logic [TW-1:0]        ul_nx;
  logic [TW-1:0]        ul_pv;
  logic [TASK_ID_W-1:0] old_q;
  logic [STATUS_W-1:0]  status_q;
  logic                 sw_q;
  logic                 lazy_q;

  // Memory ports.
  logic          next_we, prev_we, pri_we, head_we, tail_we;
  logic [TW-1:0] next_wa, next_wd, next_ra, next_rd;
  logic [TW-1:0] prev_wa, prev_wd, prev_ra, prev_rd;
  logic [TW-1:0] pri_wa, pri_ra;
  logic [PW-1:0] pri_wd, pri_rd;
  logic [PW-1:0] head_wa, head_ra, tail_wa, tail_ra;
  logic [TW-1:0] head_wd, head_rd, tail_wd, tail_rd;

  prqs_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_next (
    .clk(clk), .we(next_we), .waddr(next_wa), .wdata(next_wd),
    .raddr(next_ra), .rdata(next_rd)
  );
  prqs_ram #(.WIDTH(TW), .DEPTH(MAX_TASKS)) u_prev (
    .clk(clk), .we(prev_we), .waddr(prev_wa), .wdata(prev_wd),
    .raddr(prev_ra), .rdata(prev_rd)
  );
  prqs_ram #(.WIDTH(PW), .DEPTH(MAX_TASKS)) u_pri (
    .clk(clk), .we(pri_we), .waddr(pri_wa), .wdata(pri_wd),
    .raddr(pri_ra), .rdata(pri_rd)
  );
  prqs_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_head (
    .clk(clk), .we(head_we), .waddr(head_wa), .wdata(head_wd),
    .raddr(head_ra), .rdata(head_rd)
  );
  prqs_ram #(.WIDTH(TW), .DEPTH(PRIORITY_LEVELS)) u_tail (
    .clk(clk), .we(tail_we), .waddr(tail_wa), .wdata(tail_wd),
    .raddr(tail_ra), .rdata(tail_rd)
  );

  // Request checks on the live input word.
  logic [TW-1:0] tidx;
  logic          t_in_range;
  logic          p_in_range;
  logic          req_ok;

  assign tidx       = TW'(task_id);
  assign t_in_range = {5'd0, task_id} < 9'(MAX_TASKS);
  assign p_in_range = {4'd0, priority_req} < 9'(PRIORITY_LEVELS);

  always_comb begin
    case (command)
      CMD_ADD: begin
        req_ok = t_in_range && p_in_range && !queued_flags[tidx] &&
                 !(running_valid && running_task == tidx);
      end
      CMD_START: req_ok = t_in_range && queued_flags[tidx];
      CMD_SCHED: req_ok = running_valid;
      default:   req_ok = 1'b0;
    endcase
  end

  // Two-level search for the best non-empty level: first the group, then
  // the flag inside it.
  logic [MAP_PAD_W-1:0] map_pad;
  logic [GROUP_W-1:0]   group_any;
  logic [3:0]           low_idx;
  logic [PW-1:0]        enc_p;

  assign map_pad = MAP_PAD_W'(nonempty_map);

  always_comb begin
    for (int g = 0; g < GROUP_W; g++) begin
      group_any[g] = |map_pad[g*GROUP_W +: GROUP_W];
    end
  end

  assign low_idx = first_set16(map_pad[{gsel_q, 4'd0} +: GROUP_W]);
  assign enc_p   = PW'({gsel_q, low_idx});

  // Push target: the added task, or the preempted running task.
  logic [TW-1:0] push_t;
  logic [PW-1:0] push_p;
  logic          is_head, is_tail;

  assign push_t  = (cmd_q == CMD_ADD) ? sel_task : running_task;
  assign push_p  = (cmd_q == CMD_ADD) ? pr_q : cur_p;
  assign is_head = (head_rd == sel_task);
  assign is_tail = (tail_rd == sel_task);

  always_comb begin
    pri_ra  = ctl.srch0 ? running_task : sel_task;
    next_ra = sel_task;
    prev_ra = sel_task;
    head_ra = ctl.unl1 ? pri_rd : enc_p;
    tail_ra = ctl.unl1 ? pri_rd : push_p;

    next_we = 1'b0; next_wa = '0; next_wd = '0;
    prev_we = 1'b0; prev_wa = '0; prev_wd = '0;
    pri_we  = 1'b0; pri_wa  = '0; pri_wd  = '0;
    head_we = 1'b0; head_wa = '0; head_wd = '0;
    tail_we = 1'b0; tail_wa = '0; tail_wd = '0;

    if (ctl.unl2 && !(is_head && is_tail)) begin
      if (is_head) begin
        head_we = 1'b1; head_wa = ul_p; head_wd = ul_nx;
      end else begin
        next_we = 1'b1; next_wa = ul_pv; next_wd = is_tail ? ul_pv : ul_nx;
      end
      if (is_tail) begin
        tail_we = 1'b1; tail_wa = ul_p; tail_wd = ul_pv;
      end else begin
        prev_we = 1'b1; prev_wa = ul_nx; prev_wd = is_head ? ul_nx : ul_pv;
      end
    end

    if (ctl.push0) begin
      next_we = 1'b1; next_wa = push_t; next_wd = push_t;
      if (cmd_q == CMD_ADD) begin
        pri_we = 1'b1; pri_wa = push_t; pri_wd = push_p;
      end
    end

    if (ctl.push1) begin
      if (nonempty_map[push_p]) begin
        next_we = 1'b1; next_wa = tail_rd; next_wd = push_t;
        prev_we = 1'b1; prev_wa = push_t;  prev_wd = tail_rd;
      end else begin
        head_we = 1'b1; head_wa = push_p; head_wd = push_t;
        prev_we = 1'b1; prev_wa = push_t; prev_wd = push_t;
      end
      tail_we = 1'b1; tail_wa = push_p; tail_wd = push_t;
    end
  end

  // Control state and flags.
  always_ff @(posedge clk) begin
    if (rst) begin
      queued_flags  <= '0;
      nonempty_map  <= '0;
      running_task  <= '0;
      running_valid <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (ctl.unl2) begin
        queued_flags[sel_task] <= 1'b0;
        if (is_head && is_tail) begin
          nonempty_map[ul_p] <= 1'b0;
        end
      end
      if (ctl.push1) begin
        queued_flags[push_t] <= 1'b1;
        nonempty_map[push_p] <= 1'b1;
      end
      if (ctl.fin) begin
        running_task  <= sel_task;
        running_valid <= 1'b1;
      end
      if (ctl.ld_out) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload and working registers.
  always_ff @(posedge clk) begin
    if (ctl.ld_req) begin
      cmd_q     <= command;
      sel_task  <= tidx;
      pr_q      <= PW'(priority_req);
      cur_run_q <= current_running;
      intr_q    <= in_interrupt;
      old_q     <= running_valid ? TASK_ID_W'(running_task) : '0;
      status_q  <= req_ok ? STATUS_OK : STATUS_MISUSE;
      sw_q      <= 1'b0;
      lazy_q    <= 1'b0;
    end
    if (ctl.srch0) begin
      gsel_q  <= first_set16(group_any);
      found_q <= |group_any;
    end
    if (ctl.srch1) begin
      p_sel <= enc_p;
      cur_p <= pri_rd;
    end
    if (ctl.take_next) begin
      sel_task <= head_rd;
    end
    if (ctl.unl1) begin
      ul_p  <= pri_rd;
      ul_nx <= next_rd;
      ul_pv <= prev_rd;
    end
    if (ctl.set_empty) begin
      status_q <= STATUS_EMPTY;
    end
    if (ctl.fin) begin
      sw_q   <= 1'b1;
      lazy_q <= (cmd_q == CMD_SCHED) && intr_q;
    end
    if (ctl.ld_out) begin
      status      <= status_q;
      switched    <= sw_q;
      from_task   <= old_q;
      to_task     <= running_valid ? TASK_ID_W'(running_task) : '0;
      lazy_switch <= lazy_q;
    end
  end

  assign sts.cmd_in    = command;
  assign sts.req_ok    = req_ok;
  assign sts.cmd_q     = cmd_q;
  assign sts.cur_run   = cur_run_q;
  assign sts.found     = found_q;
  assign sts.do_switch = !(cur_run_q && (p_sel > cur_p)) && (head_rd != running_task);
  assign sts.out_free  = !out_valid || out_ready;

endmodule

`default_nettype wire
